@@ src/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TKS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tks_pkg.sv @@
// Package for the top-k score table: widths, command codes, microcode types.
// No dependencies; other src files but assert_macros.svh use its scoped names.
`timescale 1ns / 1ps

package tks_pkg;

    localparam int TABLE_ENTRIES = 10;
    localparam int NAME_BYTES    = 6;
    localparam int SLOTS         = TABLE_ENTRIES + 1;
    localparam int SLOT_W        = $clog2(SLOTS);

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int SCORE_W = 32;
    localparam int NAME_W  = 48;
    localparam int RANK_W  = 7;
    localparam int POS_W   = 4;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [NAME_W-1:0]         name;
        logic [RANK_W-1:0]         rank;
    } entry_t;

    // Program steps of the sequencer.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_READ,
        S_READ_EMIT,
        S_SUB,
        S_OUTER,
        S_CUR,
        S_INNER,
        S_ENDI,
        S_EMIT0,
        S_ERD,
        S_EMIT
    } step_t;

    typedef enum logic [2:0] {A_IDX, A_I, A_I1, A_J, A_J1} addr_sel_t;
    typedef enum logic [2:0] {WR_NONE, WR_LOAD, WR_SCRATCH, WR_J, WR_I, WR_RANK} wr_sel_t;
    typedef enum logic [1:0] {I_HOLD, I_CLR, I_INC} i_op_t;
    typedef enum logic [1:0] {J_HOLD, J_FROM_I, J_INC} j_op_t;
    typedef enum logic [1:0] {EM_NONE, EM_READ, EM_SORT} emit_t;
    typedef enum logic [2:0] {C_ALWAYS, C_ACCEPT, C_DISPATCH, C_I_MORE, C_J_MORE} cond_t;

    // One microcode word.
    typedef struct packed {
        addr_sel_t addr;
        logic      rd;
        wr_sel_t   wr;
        i_op_t     i_op;
        j_op_t     j_op;
        logic      cur_ld;
        logic      swap;
        emit_t     emit;
        cond_t     cond;
        step_t     nxt_t;
        step_t     nxt_f;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   go;
        logic   take;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             idx_ok;
        logic             i_last;
        logic             j_last;
        logic             out_free;
    } dp_stat_t;

    // Keep bytes up to the first zero byte, clear the rest.
    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v);
        logic [NAME_W-1:0] r;
        logic              live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_BYTES && b < NAME_W / 8; b++)
        begin
            if (v[8*b +: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                r[8*b +: 8] = v[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

@@ src/tks_in_if.sv @@
// Command channel of the top-k score table: valid/ready plus command payload.
// Depends on tks_pkg for field widths.
`timescale 1ns / 1ps

interface tks_in_if;
    logic                                valid;
    logic                                ready;
    logic [tks_pkg::CMD_W-1:0]           command;
    logic [tks_pkg::IDX_W-1:0]           index;
    logic signed [tks_pkg::SCORE_W-1:0]  score_in;
    logic [tks_pkg::NAME_W-1:0]          name_in;
    logic [tks_pkg::RANK_W-1:0]          rank_in;

    modport source (output valid, command, index, score_in, name_in, rank_in, input ready);
    modport sink   (input valid, command, index, score_in, name_in, rank_in, output ready);
endinterface

@@ src/tks_out_if.sv @@
// Result channel of the top-k score table: valid/ready plus one table entry.
// Depends on tks_pkg for field widths.
`timescale 1ns / 1ps

interface tks_out_if;
    logic                                valid;
    logic                                ready;
    logic [tks_pkg::POS_W-1:0]           position;
    logic signed [tks_pkg::SCORE_W-1:0]  score_out;
    logic [tks_pkg::RANK_W-1:0]          rank_out;
    logic [tks_pkg::NAME_W-1:0]          name_out;
    logic                                last;

    modport source (output valid, position, score_out, rank_out, name_out, last, input ready);
    modport sink   (input valid, position, score_out, rank_out, name_out, last, output ready);
endinterface

@@ src/tks_seq.sv @@
// Microcode sequencer: step register, control store and jump logic.
// Depends on tks_pkg for the step, control word and status types.
`timescale 1ns / 1ps

module tks_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tks_pkg::dp_stat_t stat,
    output tks_pkg::dp_ctrl_t ctrl
);

    tks_pkg::step_t  step_reg;
    tks_pkg::step_t  step_next;
    tks_pkg::uword_t uw;
    logic            go;
    logic            take;

    // Control store.
    function automatic tks_pkg::uword_t rom(input tks_pkg::step_t s);
        tks_pkg::uword_t w;
        w.addr   = tks_pkg::A_I;
        w.rd     = 1'b0;
        w.wr     = tks_pkg::WR_NONE;
        w.i_op   = tks_pkg::I_HOLD;
        w.j_op   = tks_pkg::J_HOLD;
        w.cur_ld = 1'b0;
        w.swap   = 1'b0;
        w.emit   = tks_pkg::EM_NONE;
        w.cond   = tks_pkg::C_ALWAYS;
        w.nxt_t  = tks_pkg::S_IDLE;
        w.nxt_f  = tks_pkg::S_IDLE;
        unique case (s)
            tks_pkg::S_IDLE:
            begin
                w.cond  = tks_pkg::C_ACCEPT;
                w.nxt_t = tks_pkg::S_DECODE;
            end
            tks_pkg::S_DECODE:
            begin
                w.cond = tks_pkg::C_DISPATCH;
            end
            tks_pkg::S_LOAD:
            begin
                w.wr = tks_pkg::WR_LOAD;
            end
            tks_pkg::S_READ:
            begin
                w.addr  = tks_pkg::A_IDX;
                w.rd    = 1'b1;
                w.nxt_t = tks_pkg::S_READ_EMIT;
            end
            tks_pkg::S_READ_EMIT:
            begin
                w.emit = tks_pkg::EM_READ;
            end
            tks_pkg::S_SUB:
            begin
                w.wr    = tks_pkg::WR_SCRATCH;
                w.i_op  = tks_pkg::I_CLR;
                w.nxt_t = tks_pkg::S_OUTER;
            end
            tks_pkg::S_OUTER:
            begin
                w.addr  = tks_pkg::A_I;
                w.rd    = 1'b1;
                w.j_op  = tks_pkg::J_FROM_I;
                w.nxt_t = tks_pkg::S_CUR;
            end
            tks_pkg::S_CUR:
            begin
                w.cur_ld = 1'b1;
                w.addr   = tks_pkg::A_J;
                w.rd     = 1'b1;
                w.nxt_t  = tks_pkg::S_INNER;
            end
            tks_pkg::S_INNER:
            begin
                w.swap  = 1'b1;
                w.wr    = tks_pkg::WR_J;
                w.addr  = tks_pkg::A_J1;
                w.rd    = 1'b1;
                w.j_op  = tks_pkg::J_INC;
                w.cond  = tks_pkg::C_J_MORE;
                w.nxt_t = tks_pkg::S_INNER;
                w.nxt_f = tks_pkg::S_ENDI;
            end
            tks_pkg::S_ENDI:
            begin
                w.wr    = tks_pkg::WR_I;
                w.i_op  = tks_pkg::I_INC;
                w.cond  = tks_pkg::C_I_MORE;
                w.nxt_t = tks_pkg::S_OUTER;
                w.nxt_f = tks_pkg::S_EMIT0;
            end
            tks_pkg::S_EMIT0:
            begin
                w.i_op  = tks_pkg::I_CLR;
                w.nxt_t = tks_pkg::S_ERD;
            end
            tks_pkg::S_ERD:
            begin
                w.addr  = tks_pkg::A_I;
                w.rd    = 1'b1;
                w.nxt_t = tks_pkg::S_EMIT;
            end
            tks_pkg::S_EMIT:
            begin
                w.emit  = tks_pkg::EM_SORT;
                w.wr    = tks_pkg::WR_RANK;
                w.addr  = tks_pkg::A_I1;
                w.rd    = 1'b1;
                w.i_op  = tks_pkg::I_INC;
                w.cond  = tks_pkg::C_I_MORE;
                w.nxt_t = tks_pkg::S_EMIT;
                w.nxt_f = tks_pkg::S_IDLE;
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tks_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        uw        = rom(step_reg);
        req_ready = (step_reg == tks_pkg::S_IDLE);
        take      = req_ready && req_valid;
        // hold the step while an emit waits for the output register
        go        = (uw.emit == tks_pkg::EM_NONE) || stat.out_free;
        step_next = step_reg;
        if (go)
        begin
            unique case (uw.cond)
                tks_pkg::C_ALWAYS:   step_next = uw.nxt_t;
                tks_pkg::C_ACCEPT:   step_next = take ? uw.nxt_t : uw.nxt_f;
                tks_pkg::C_I_MORE:   step_next = !stat.i_last ? uw.nxt_t : uw.nxt_f;
                tks_pkg::C_J_MORE:   step_next = !stat.j_last ? uw.nxt_t : uw.nxt_f;
                tks_pkg::C_DISPATCH:
                begin
                    unique case (stat.cmd)
                        tks_pkg::CMD_LOAD:
                            step_next = stat.idx_ok ? tks_pkg::S_LOAD : tks_pkg::S_IDLE;
                        tks_pkg::CMD_SUBMIT:
                            step_next = tks_pkg::S_SUB;
                        tks_pkg::CMD_READ:
                            step_next = stat.idx_ok ? tks_pkg::S_READ : tks_pkg::S_IDLE;
                        default:
                            step_next = tks_pkg::S_IDLE;
                    endcase
                end
                default:             step_next = tks_pkg::S_IDLE;
            endcase
        end
        ctrl.uw   = uw;
        ctrl.go   = go;
        ctrl.take = take;
    end

endmodule

@@ src/tks_dp.sv @@
// Datapath: slot memory, pass counters, carried entry, rank logic, output register.
// Depends on tks_pkg; driven by the control word from tks_seq.
`timescale 1ns / 1ps

module tks_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tks_pkg::dp_ctrl_t                  ctrl,
    input  logic [tks_pkg::CMD_W-1:0]          command,
    input  logic [tks_pkg::IDX_W-1:0]          index,
    input  logic signed [tks_pkg::SCORE_W-1:0] score_in,
    input  logic [tks_pkg::NAME_W-1:0]         name_in,
    input  logic [tks_pkg::RANK_W-1:0]         rank_in,
    input  logic                               out_ready,
    output tks_pkg::dp_stat_t                  stat,
    output logic                               out_valid,
    output logic [tks_pkg::POS_W-1:0]          position,
    output logic signed [tks_pkg::SCORE_W-1:0] score_out,
    output logic [tks_pkg::RANK_W-1:0]         rank_out,
    output logic [tks_pkg::NAME_W-1:0]         name_out,
    output logic                               last
);

    localparam int SW = tks_pkg::SLOT_W;
    localparam int RW = tks_pkg::RANK_W;
    localparam int PW = tks_pkg::POS_W;

    // latched command
    logic [tks_pkg::CMD_W-1:0]          cmd_reg;
    logic [tks_pkg::IDX_W-1:0]          idx_reg;
    logic signed [tks_pkg::SCORE_W-1:0] score_reg;
    logic [tks_pkg::NAME_W-1:0]         name_reg;
    logic [RW-1:0]                      rank_reg;

    tks_pkg::slot_t  i_reg;
    tks_pkg::slot_t  j_reg;
    tks_pkg::entry_t cur_reg;

    tks_pkg::entry_t                    mem [tks_pkg::SLOTS];
    logic [tks_pkg::SLOTS-1:0]          vld_reg;
    tks_pkg::entry_t                    rd_reg;
    logic                               rvld_reg;
    tks_pkg::entry_t                    rd_ent;

    logic signed [tks_pkg::SCORE_W-1:0] prev_score_reg;
    logic [RW-1:0]                      prev_rank_reg;
    logic [RW-1:0]                      rank_calc;

    logic                               out_valid_reg;
    logic [PW-1:0]                      pos_reg;
    logic signed [tks_pkg::SCORE_W-1:0] oscore_reg;
    logic [RW-1:0]                      orank_reg;
    logic [tks_pkg::NAME_W-1:0]         oname_reg;
    logic                               olast_reg;

    tks_pkg::slot_t  rd_addr;
    logic            rd_en;
    tks_pkg::slot_t  wr_addr;
    tks_pkg::entry_t wr_data;
    logic            wr_en;
    logic            swap_hit;
    logic            out_free;
    logic            i_last;
    logic            emit_go;

    assign rd_ent   = rvld_reg ? rd_reg : '0;
    assign swap_hit = $signed(cur_reg.score) <= $signed(rd_ent.score);
    assign i_last   = (i_reg == SW'(tks_pkg::TABLE_ENTRIES - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign emit_go  = ctrl.go && (ctrl.uw.emit != tks_pkg::EM_NONE);

    assign stat.cmd      = cmd_reg;
    assign stat.idx_ok   = (idx_reg < tks_pkg::IDX_W'(tks_pkg::TABLE_ENTRIES));
    assign stat.i_last   = i_last;
    assign stat.j_last   = (j_reg == SW'(tks_pkg::SLOTS - 1));
    assign stat.out_free = out_free;

    // competition rank over a descending table
    always_comb
    begin
        if (i_reg == '0)
        begin
            rank_calc = RW'(1);
        end
        else if (rd_ent.score == prev_score_reg)
        begin
            rank_calc = prev_rank_reg;
        end
        else
        begin
            rank_calc = RW'(i_reg) + RW'(1);
        end
    end

    always_comb
    begin
        unique case (ctrl.uw.addr)
            tks_pkg::A_IDX: rd_addr = SW'(idx_reg);
            tks_pkg::A_I:   rd_addr = i_reg;
            tks_pkg::A_I1:  rd_addr = i_reg + SW'(1);
            tks_pkg::A_J:   rd_addr = j_reg;
            tks_pkg::A_J1:  rd_addr = j_reg + SW'(1);
            default:        rd_addr = i_reg;
        endcase
        // drop reads past the scratch slot
        rd_en = ctrl.go && ctrl.uw.rd && (int'(rd_addr) < tks_pkg::SLOTS);
    end

    always_comb
    begin
        wr_addr = i_reg;
        wr_data = cur_reg;
        wr_en   = 1'b0;
        unique case (ctrl.uw.wr)
            tks_pkg::WR_NONE:
            begin
                wr_en = 1'b0;
            end
            tks_pkg::WR_LOAD:
            begin
                wr_addr = SW'(idx_reg);
                wr_data = '{score: score_reg, name: name_reg, rank: rank_reg};
                wr_en   = 1'b1;
            end
            tks_pkg::WR_SCRATCH:
            begin
                wr_addr = SW'(tks_pkg::SLOTS - 1);
                wr_data = '{score: score_reg, name: name_reg, rank: '0};
                wr_en   = 1'b1;
            end
            tks_pkg::WR_J:
            begin
                wr_addr = j_reg;
                wr_data = cur_reg;
                wr_en   = swap_hit;
            end
            tks_pkg::WR_I:
            begin
                wr_addr = i_reg;
                wr_data = cur_reg;
                wr_en   = 1'b1;
            end
            tks_pkg::WR_RANK:
            begin
                wr_addr = i_reg;
                wr_data = '{score: rd_ent.score, name: rd_ent.name, rank: rank_calc};
                wr_en   = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        wr_en = wr_en && ctrl.go;
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // latch the command beat
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            cmd_reg   <= command;
            idx_reg   <= index;
            score_reg <= score_in;
            name_reg  <= tks_pkg::norm_name(name_in);
            rank_reg  <= rank_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (ctrl.go)
        begin
            unique case (ctrl.uw.i_op)
                tks_pkg::I_CLR:  i_reg <= '0;
                tks_pkg::I_INC:  i_reg <= i_reg + SW'(1);
                default:         i_reg <= i_reg;
            endcase
            unique case (ctrl.uw.j_op)
                tks_pkg::J_FROM_I: j_reg <= i_reg + SW'(1);
                tks_pkg::J_INC:    j_reg <= j_reg + SW'(1);
                default:           j_reg <= j_reg;
            endcase
        end
    end

    // carried entry of the exchange pass
    always_ff @(posedge clk)
    begin
        if (ctrl.go && (ctrl.uw.cur_ld || (ctrl.uw.swap && swap_hit)))
        begin
            cur_reg <= rd_ent;
        end
        if (emit_go && (ctrl.uw.emit == tks_pkg::EM_SORT))
        begin
            prev_score_reg <= rd_ent.score;
            prev_rank_reg  <= rank_calc;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            oscore_reg <= rd_ent.score;
            oname_reg  <= rd_ent.name;
            if (ctrl.uw.emit == tks_pkg::EM_READ)
            begin
                pos_reg   <= PW'(idx_reg);
                orank_reg <= rd_ent.rank;
                olast_reg <= 1'b1;
            end
            else
            begin
                pos_reg   <= PW'(i_reg);
                orank_reg <= rank_calc;
                olast_reg <= i_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = pos_reg;
    assign score_out = oscore_reg;
    assign rank_out  = orank_reg;
    assign name_out  = oname_reg;
    assign last      = olast_reg;

endmodule

@@ src/top_k_score_table.sv @@
// Top level of the top-k score table: sequencer plus datapath on two channels.
// Depends on tks_pkg, tks_in_if, tks_out_if, tks_seq and tks_dp.
`timescale 1ns / 1ps
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------------------
//  req      in   command, index, score_in, name_in, rank_in
//  rsp      out  position, score_out, rank_out, name_out, last
//
//  One command at a time. After decode a load writes its slot and a read
//  fetches its slot into the output register. A submit makes exchange passes,
//  one compare-swap per cycle through the slot memory (a read and a write
//  port), then one result per cycle while rsp is ready, rank written back.
//  Reset clears the per-slot valid bits, so every slot reads as zero at once.
//  A stalled rsp holds the sequencer on its emit step; req is taken again as
//  soon as the last result sits in the output register.

module top_k_score_table (
    input  logic      clk,
    input  logic      rst_n,
    tks_in_if.sink    req,
    tks_out_if.source rsp
);

    tks_pkg::dp_ctrl_t ctrl;
    tks_pkg::dp_stat_t stat;

    // step register and control store
    tks_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // slot memory, counters, compare, rank and output register
    tks_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .command   (req.command),
        .index     (req.index),
        .score_in  (req.score_in),
        .name_in   (req.name_in),
        .rank_in   (req.rank_in),
        .out_ready (rsp.ready),
        .stat      (stat),
        .out_valid (rsp.valid),
        .position  (rsp.position),
        .score_out (rsp.score_out),
        .rank_out  (rsp.rank_out),
        .name_out  (rsp.name_out),
        .last      (rsp.last)
    );

endmodule

@@ src/tks_chk.sv @@
// Port-level checker for the top-k score table, bound to the top level.
// Depends on tks_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tks_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [tks_pkg::POS_W-1:0]          rsp_position,
    input logic signed [tks_pkg::SCORE_W-1:0] rsp_score_out,
    input logic [tks_pkg::RANK_W-1:0]         rsp_rank_out,
    input logic [tks_pkg::NAME_W-1:0]         rsp_name_out,
    input logic                               rsp_last
);

    // a stalled result beat holds
    `TKS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_score_out) && $stable(rsp_name_out) && $stable(rsp_position), "rsp beat changed while stalled")

    // the top entry of a submit always ranks first
    `TKS_ASSERT_NOW(a_top_rank, clk, rst_n, rsp_valid && !rsp_last && (rsp_position == '0), rsp_rank_out == tks_pkg::RANK_W'(1), "top entry of submit not ranked 1")

    // no new command while a submit still has results to send
    `TKS_ASSERT_NOW(a_busy_mid, clk, rst_n, rsp_valid && !rsp_last, !req_ready, "req ready in the middle of a submit")

    // a command beat always occupies the block for the next cycle
    `TKS_ASSERT_NEXT(a_busy_after, clk, rst_n, req_valid && req_ready, !req_ready, "req ready right after a command beat")

endmodule

bind top_k_score_table tks_chk u_tks_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_position  (rsp.position),
    .rsp_score_out (rsp.score_out),
    .rsp_rank_out  (rsp.rank_out),
    .rsp_name_out  (rsp.name_out),
    .rsp_last      (rsp.last)
);

@@ sim/tks_score_checker.sv @@
// Scoreboard for the top-k score table: watches both channels, predicts every result beat.
// Depends on tks_pkg, tks_in_if and tks_out_if from the RTL.
`timescale 1ns / 1ps

module tks_score_checker
    import tks_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tks_in_if    req,
    tks_out_if   rsp,
    output int   fail_count,
    output int   pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic signed [SCORE_W-1:0] score;
        logic [RANK_W-1:0]         rank;
        logic [NAME_W-1:0]         name;
        logic                      last;
    } table_row_t;

    table_row_t                rows_due[$];
    logic signed [SCORE_W-1:0] slot_score [SLOTS];
    logic [NAME_W-1:0]         slot_name  [SLOTS];
    logic [RANK_W-1:0]         slot_rank  [SLOTS];
    int                        misses;

    // Cut the name at its first zero byte.
    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        int                b;
        kept = '0;
        b    = 0;
        while (b < NAME_BYTES && raw[8*b +: 8] != 8'h00)
        begin
            kept[8*b +: 8] = raw[8*b +: 8];
            b++;
        end
        return kept;
    endfunction

    function automatic table_row_t slot_row(input int pos, input logic is_last);
        table_row_t r;
        r.position = POS_W'(pos);
        r.score    = slot_score[pos];
        r.rank     = slot_rank[pos];
        r.name     = slot_name[pos];
        r.last     = is_last;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        table_row_t                got;
        table_row_t                want;
        logic signed [SCORE_W-1:0] tmp_score;
        logic [NAME_W-1:0]         tmp_name;
        int                        r;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_score[k] = '0;
                slot_name[k]  = '0;
                slot_rank[k]  = '0;
            end
            rows_due.delete();
            misses     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Compare the result beat first: it always belongs to an older command.
            if (rsp.valid && rsp.ready)
            begin
                got.position = rsp.position;
                got.score    = rsp.score_out;
                got.rank     = rsp.rank_out;
                got.name     = rsp.name_out;
                got.last     = rsp.last;
                if (rows_due.size() == 0)
                begin
                    if (misses < REPORT_MAX)
                        $display("unexpected result: pos=%0d score=%0d rank=%0d name=%h last=%b",
                                 got.position, got.score, got.rank, got.name, got.last);
                    misses++;
                end
                else
                begin
                    want = rows_due.pop_front();
                    if (got.position !== want.position || got.score !== want.score ||
                        got.rank !== want.rank || got.name !== want.name ||
                        got.last !== want.last)
                    begin
                        if (misses < REPORT_MAX)
                        begin
                            $display("result mismatch: expected pos=%0d score=%0d rank=%0d name=%h last=%b",
                                     want.position, want.score, want.rank, want.name, want.last);
                            $display("                 actual   pos=%0d score=%0d rank=%0d name=%h last=%b",
                                     got.position, got.score, got.rank, got.name, got.last);
                        end
                        misses++;
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                case (req.command)
                    CMD_LOAD:
                    begin
                        if (req.index < TABLE_ENTRIES)
                        begin
                            slot_score[req.index] = req.score_in;
                            slot_name[req.index]  = trim_name(req.name_in);
                            slot_rank[req.index]  = req.rank_in;
                        end
                    end
                    CMD_READ:
                    begin
                        if (req.index < TABLE_ENTRIES)
                            rows_due.push_back(slot_row(int'(req.index), 1'b1));
                    end
                    CMD_SUBMIT:
                    begin
                        slot_score[TABLE_ENTRIES] = req.score_in;
                        slot_name[TABLE_ENTRIES]  = trim_name(req.name_in);
                        // Exchange sort, descending; equal scores swap too.
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                        begin
                            for (int j = i + 1; j < SLOTS; j++)
                            begin
                                if (slot_score[i] <= slot_score[j])
                                begin
                                    tmp_score     = slot_score[i];
                                    tmp_name      = slot_name[i];
                                    slot_score[i] = slot_score[j];
                                    slot_name[i]  = slot_name[j];
                                    slot_score[j] = tmp_score;
                                    slot_name[j]  = tmp_name;
                                end
                            end
                        end
                        // Competition ranks over every slot, scratch included.
                        for (int j = 0; j < SLOTS; j++)
                        begin
                            r = 1;
                            for (int i = 0; i < j && i < TABLE_ENTRIES; i++)
                            begin
                                if (slot_score[i] > slot_score[j])
                                    r++;
                            end
                            slot_rank[j] = RANK_W'(r);
                        end
                        for (int p = 0; p < TABLE_ENTRIES; p++)
                            rows_due.push_back(slot_row(p, p == TABLE_ENTRIES - 1));
                    end
                    default:
                    begin
                    end
                endcase
            end
            fail_count <= misses;
            pending    <= rows_due.size();
        end
    end

endmodule

@@ sim/tb_top_k_score_table.sv @@
// Testbench top for the top-k score table: clock, reset, command stimulus, verdict.
// Depends on tks_pkg, tks_in_if, tks_out_if, top_k_score_table and tks_score_checker.
`timescale 1ns / 1ps

module tb_top_k_score_table;
    import tks_pkg::*;

    // Command code the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;
    // Extra wait after the last drain, before the verdict.
    localparam int TAIL_CYCLES = 150;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          rows_pending;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int          stall_seq;
    int          cycle_count;

    tks_in_if  req_bus ();
    tks_out_if rsp_bus ();

    top_k_score_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    tks_score_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_bus),
        .rsp        (rsp_bus),
        .fail_count (fail_count),
        .pending    (rows_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: if the run hangs anywhere, end it here as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("top_k_score_table verification failed");
        $finish;
    end

    // Result receiver: drop ready at random per the current idle share, and
    // hold it low for a long stretch whenever the stimulus bumps stall_seq.
    initial
    begin
        int hold_left;
        int seen_seq;
        rsp_bus.ready = 1'b0;
        hold_left     = 0;
        seen_seq      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_seq != seen_seq)
            begin
                seen_seq  = stall_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Scores: many small values so ties are common, some extremes, the rest wide.
    function automatic logic signed [SCORE_W-1:0] rand_score();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return SCORE_W'($urandom_range(0, 6)) - 32'sd3;
        if (pick < 45)
        begin
            case ($urandom_range(0, 3))
                0:       return SCORE_MIN;
                1:       return SCORE_MAX;
                2:       return SCORE_MIN + 32'sd1;
                default: return SCORE_MAX - 32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    // Names: mostly printable-ish bytes with the odd zero byte inside, so the
    // cut at the first zero is hit with live bytes after it.
    function automatic logic [NAME_W-1:0] rand_name();
        logic [NAME_W-1:0] v;
        if ($urandom_range(0, 9) == 0)
        begin
            v[31:0]  = $urandom();
            v[47:32] = 16'($urandom());
            return v;
        end
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if ($urandom_range(0, 99) < 12)
                v[8*b +: 8] = 8'h00;
            else
                v[8*b +: 8] = 8'($urandom_range(1, 255));
        end
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        return IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    endfunction

    function automatic logic [RANK_W-1:0] rand_rank();
        return RANK_W'($urandom_range(0, 127));
    endfunction

    // Offer one command beat, idling first per the sender's share, and
    // return at the edge where the block takes it.
    task automatic send_item(input logic [CMD_W-1:0]          cmd,
                             input logic [IDX_W-1:0]          idx,
                             input logic signed [SCORE_W-1:0] score,
                             input logic [NAME_W-1:0]         name,
                             input logic [RANK_W-1:0]         rank);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.command  <= cmd;
        req_bus.index    <= idx;
        req_bus.score_in <= score;
        req_bus.name_in  <= name;
        req_bus.rank_in  <= rank;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Drop valid and hold the sender until every predicted beat has arrived.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (rows_pending != 0);
    endtask

    // Random mix: mostly loads, submits and reads at legal positions; a tenth
    // is noise (unused command, out-of-range position) that does not count.
    task automatic run_random_phase(input int          n_items,
                                    input int unsigned tx_pct,
                                    input int unsigned rx_pct,
                                    input int          stall_at);
        int          done;
        int unsigned sel;
        logic        stalled;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done        = 0;
        stalled     = 1'b0;
        while (done < n_items)
        begin
            if (done == stall_at && !stalled)
            begin
                stalled = 1'b1;
                stall_seq++;
            end
            sel = $urandom_range(0, 99);
            if (sel < 35)
            begin
                send_item(CMD_LOAD, rand_index(), rand_score(), rand_name(), rand_rank());
                done++;
            end
            else if (sel < 65)
            begin
                send_item(CMD_SUBMIT, IDX_W'($urandom()), rand_score(), rand_name(),
                          rand_rank());
                done++;
            end
            else if (sel < 90)
            begin
                send_item(CMD_READ, rand_index(), rand_score(), rand_name(), rand_rank());
                done++;
            end
            else if (sel < 95)
            begin
                send_item(CMD_UNUSED, IDX_W'($urandom()), rand_score(), rand_name(),
                          rand_rank());
            end
            else
            begin
                send_item(($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_READ,
                          IDX_W'($urandom_range(TABLE_ENTRIES, 15)), rand_score(),
                          rand_name(), rand_rank());
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.command  = CMD_LOAD;
        req_bus.index    = '0;
        req_bus.score_in = '0;
        req_bus.name_in  = '0;
        req_bus.rank_in  = '0;
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        stall_seq        = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads of the cleared table, extreme loads, ignored beats,
        // name cut at a zero byte, ties at both score extremes and at zero.
        send_item(CMD_READ,   4'd0,  32'sd0,    48'h0, 7'd0);
        send_item(CMD_READ,   4'd9,  32'sd0,    48'h0, 7'd0);
        send_item(CMD_LOAD,   4'd0,  SCORE_MAX, 48'hFFFF_FFFF_FFFF, 7'h7F);
        send_item(CMD_LOAD,   4'd9,  SCORE_MIN, 48'h0, 7'd0);
        send_item(CMD_LOAD,   4'd10, 32'sd123,  48'h0000_0000_4142, 7'd5);
        send_item(CMD_READ,   4'd15, 32'sd0,    48'h0, 7'd0);
        send_item(CMD_UNUSED, 4'd3,  32'sd77,   48'hFFFF_FFFF_FFFF, 7'h7F);
        send_item(CMD_READ,   4'd0,  32'sd0,    48'h0, 7'd0);
        send_item(CMD_READ,   4'd9,  32'sd0,    48'h0, 7'd0);
        send_item(CMD_LOAD,   4'd4,  -32'sd5,   48'h5A59_0043_4241, 7'd99);
        send_item(CMD_READ,   4'd4,  32'sd0,    48'h0, 7'd0);
        send_item(CMD_SUBMIT, 4'd0,  32'sd0,    48'h4400_0000_4241, 7'd0);
        send_item(CMD_SUBMIT, 4'd15, SCORE_MIN, 48'hFFFF_FFFF_FF00, 7'h7F);
        send_item(CMD_SUBMIT, 4'd7,  SCORE_MAX, 48'h3635_3433_3231, 7'd1);
        send_item(CMD_SUBMIT, 4'd2,  SCORE_MAX, 48'h4646_4545_4444, 7'd2);
        send_item(CMD_SUBMIT, 4'd0,  32'sd0,    48'h0000_0000_005A, 7'd0);
        send_item(CMD_LOAD,   4'd8,  -32'sd1,   48'hFF00_FF00_FF01, 7'd0);
        send_item(CMD_SUBMIT, 4'd8,  -32'sd1,   48'h0000_0000_0000, 7'd64);
        send_item(CMD_READ,   4'd10, 32'sd0,    48'h0, 7'd0);
        send_item(CMD_READ,   4'd8,  32'sd0,    48'h0, 7'd0);
        wait_drained();

        // Random phases: sender light and receiver heavy with one long
        // receiver hold-off, then the reverse, then no idling at all.
        run_random_phase(55, 36, 59, 20);
        wait_drained();
        run_random_phase(55, 59, 36, -1);
        wait_drained();
        run_random_phase(55, 0, 0, -1);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && rows_pending == 0)
            $display("top_k_score_table verification clean");
        else
            $display("top_k_score_table verification failed");
        $finish;
    end

endmodule
